// ===== hw/rtl/hds_pkg.sv =====
// Shared constants, widths and types for the 3D heat diffusion stencil.
// No dependencies; every file of the block but hds_ram imports this package.
`timescale 1ns / 1ps

package hds_pkg;

  // Interior volume size
  localparam int EDGE_SIZE     = 16;
  localparam int COLUMN_HEIGHT = 64;

  // Padded volume, halo included
  localparam int PAD_X       = EDGE_SIZE + 2;
  localparam int PAD_Y       = COLUMN_HEIGHT + 2;
  localparam int PAD_Z       = EDGE_SIZE + 2;
  localparam int PLANE_WORDS = PAD_X * PAD_Y;

  // Position counter widths
  localparam int COL_W   = $clog2(PAD_X);
  localparam int ROW_W   = $clog2(PAD_Y);
  localparam int PLANE_W = $clog2(PAD_Z);

  // Result coordinate field widths
  localparam int POS_X_W = 4;
  localparam int POS_Y_W = 6;
  localparam int POS_Z_W = 4;

  // Delay memories: a short one spanning about one row, a long one about one plane
  localparam int LINE_DEPTH  = PAD_X - 2;
  localparam int PLANE_DEPTH = PLANE_WORDS - PAD_X - 1;
  localparam int LINE_AW     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PLANE_AW    = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

  // Arithmetic widths
  localparam int TEMP_W  = 16;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = TEMP_W + 3;
  localparam int DIFF_W  = TEMP_W + 4;
  localparam int PROD_W  = DIFF_W + COEF_W + 1;
  localparam int DELTA_W = PROD_W - FRAC_W;
  localparam int RES_W   = DELTA_W + 1;

  localparam int TEMP_MAX = 2 ** (TEMP_W - 1) - 1;
  localparam int TEMP_MIN = -(2 ** (TEMP_W - 1));

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [COEF_W-1:0]        coef_t;

  // The seven stencil points of one interior voxel
  typedef struct packed {
    temp_t above;
    temp_t north;
    temp_t right;
    temp_t center;
    temp_t left;
    temp_t south;
    temp_t below;
  } taps_t;

  // Position and end-of-volume mark that travel with a result
  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_Z_W-1:0] pos_z;
    logic               last;
  } tag_t;

endpackage

// ===== hw/rtl/hds_if.sv =====
// Valid/ready channel interfaces for the voxel input and the result output.
// Depends on hds_pkg for field widths.
`timescale 1ns / 1ps

interface hds_voxel_if import hds_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t temperature;
  logic  frame_start;

  modport source(output valid, temperature, frame_start, input ready);
  modport sink(input valid, temperature, frame_start, output ready);
endinterface

interface hds_result_if import hds_pkg::*; ();
  logic               valid;
  logic               ready;
  temp_t              next_temperature;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [POS_Z_W-1:0] pos_z;
  logic               saturated;
  logic               last;

  modport source(output valid, next_temperature, pos_x, pos_y, pos_z, saturated, last,
                 input ready);
  modport sink(input valid, next_temperature, pos_x, pos_y, pos_z, saturated, last,
               output ready);
endinterface

// ===== hw/rtl/hds_ram.sv =====
// Generic single-clock RAM, one write and one read port, registered read-first output.
// No dependencies.
`timescale 1ns / 1ps

module hds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Same-address read and write return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hds_window.sv =====
// Voxel intake: position counters, the two delay memories and the stencil window.
// Depends on hds_pkg, hds_if and hds_ram.
`timescale 1ns / 1ps

module hds_window import hds_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hds_voxel_if.sink     voxel,
  input  logic          advance,
  output logic          win_valid,
  output taps_t         taps,
  output tag_t          tag
);

  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [PLANE_W-1:0] plane_cnt;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [PLANE_W-1:0] z;
  logic [COL_W-1:0]   xm1;
  logic [ROW_W-1:0]   ym1;
  logic [PLANE_W-1:0] zm2;
  logic               accept;
  logic               interior;

  logic [LINE_AW-1:0]    line_ptr;
  logic [PLANE_AW-1:0]   plane_ptr;
  logic [2*TEMP_W-1:0]   line_rdata;
  logic [2*TEMP_W-1:0]   plane_rdata;
  logic [2*TEMP_W-1:0]   line_wdata;
  logic [2*TEMP_W-1:0]   plane_wdata;

  temp_t above_q;
  temp_t center_q;
  temp_t left_q;

  assign voxel.ready = !win_valid || advance;
  assign accept      = voxel.valid && voxel.ready;

  // A frame start places its voxel at the origin
  assign x = voxel.frame_start ? '0 : col_cnt;
  assign y = voxel.frame_start ? '0 : row_cnt;
  assign z = voxel.frame_start ? '0 : plane_cnt;

  assign interior = (z >= PLANE_W'(2)) &&
                    (x >= COL_W'(1)) && (x <= COL_W'(PAD_X - 2)) &&
                    (y >= ROW_W'(1)) && (y <= ROW_W'(PAD_Y - 2));

  assign xm1 = x - COL_W'(1);
  assign ym1 = y - ROW_W'(1);
  assign zm2 = z - PLANE_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      plane_cnt <= '0;
      win_valid <= 1'b0;
      line_ptr  <= '0;
      plane_ptr <= '0;
    end else begin
      if (voxel.ready) begin
        win_valid <= accept && interior;
      end
      if (accept) begin
        // Advance raster position, wrap at the end of the padded volume
        if (x == COL_W'(PAD_X - 1)) begin
          col_cnt <= '0;
          if (y == ROW_W'(PAD_Y - 1)) begin
            row_cnt   <= '0;
            plane_cnt <= (z == PLANE_W'(PAD_Z - 1)) ? '0 : z + PLANE_W'(1);
          end else begin
            row_cnt   <= y + ROW_W'(1);
            plane_cnt <= z;
          end
        end else begin
          col_cnt   <= x + COL_W'(1);
          row_cnt   <= y;
          plane_cnt <= z;
        end
        line_ptr  <= (line_ptr == LINE_AW'(LINE_DEPTH - 1)) ? '0 : line_ptr + LINE_AW'(1);
        plane_ptr <= (plane_ptr == PLANE_AW'(PLANE_DEPTH - 1)) ? '0
                                                               : plane_ptr + PLANE_AW'(1);
      end
    end
  end

  // Window registers and result tag, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      above_q   <= voxel.temperature;
      center_q  <= line_rdata[TEMP_W-1:0];
      left_q    <= center_q;
      tag.pos_x <= POS_X_W'(xm1);
      tag.pos_y <= POS_Y_W'(ym1);
      tag.pos_z <= POS_Z_W'(zm2);
      tag.last  <= (x == COL_W'(PAD_X - 2)) && (y == ROW_W'(PAD_Y - 2)) &&
                   (z == PLANE_W'(PAD_Z - 1));
    end
  end

  // Plane memory: low half delays the stream to the north neighbor,
  // high half delays the south neighbor to the voxel below
  assign plane_wdata = {line_rdata[2*TEMP_W-1:TEMP_W], above_q};
  // Line memory: low half feeds right/center/left, high half feeds south
  assign line_wdata  = {left_q, plane_rdata[TEMP_W-1:0]};

  hds_ram #(
    .WIDTH(2 * TEMP_W),
    .DEPTH(PLANE_DEPTH)
  ) u_plane_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(plane_ptr),
    .wdata(plane_wdata),
    .re   (accept),
    .raddr(plane_ptr),
    .rdata(plane_rdata)
  );

  hds_ram #(
    .WIDTH(2 * TEMP_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(line_ptr),
    .wdata(line_wdata),
    .re   (accept),
    .raddr(line_ptr),
    .rdata(line_rdata)
  );

  assign taps.above  = above_q;
  assign taps.north  = plane_rdata[TEMP_W-1:0];
  assign taps.right  = line_rdata[TEMP_W-1:0];
  assign taps.center = center_q;
  assign taps.left   = left_q;
  assign taps.south  = line_rdata[2*TEMP_W-1:TEMP_W];
  assign taps.below  = plane_rdata[2*TEMP_W-1:TEMP_W];

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt < COL_W'(PAD_X) && row_cnt < ROW_W'(PAD_Y) && plane_cnt < PLANE_W'(PAD_Z))
    else $error("position counter out of range");

  a_hold_window: assert property (@(posedge clk) disable iff (rst)
    !voxel.ready |=> $stable(taps) && $stable(win_valid))
    else $error("window changed while intake was stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    win_valid && tag.last |->
      tag.pos_x == POS_X_W'(EDGE_SIZE - 1) && tag.pos_y == POS_Y_W'(COLUMN_HEIGHT - 1) &&
      tag.pos_z == POS_Z_W'(EDGE_SIZE - 1))
    else $error("last mark on a voxel that is not the final interior one");

endmodule

// ===== hw/rtl/hds_update.sv =====
// Update pipeline: neighbor sum, coefficient multiply, shift, saturate, result register.
// Depends on hds_pkg and hds_if.
`timescale 1ns / 1ps

module hds_update import hds_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          win_valid,
  input  taps_t         taps,
  input  tag_t          tag,
  input  coef_t         coeff,
  output logic          advance,
  hds_result_if.source  result
);

  logic                     adv_mul;
  logic                     adv_out;

  logic signed [DIFF_W-1:0] diff_next;
  logic signed [DIFF_W-1:0] center_x;
  logic signed [DIFF_W-1:0] nb_sum;

  logic                     dif_valid;
  logic signed [DIFF_W-1:0] dif_diff;
  temp_t                    dif_center;
  tag_t                     dif_tag;

  logic                     mul_valid;
  logic signed [PROD_W-1:0] mul_prod;
  temp_t                    mul_center;
  tag_t                     mul_tag;

  logic signed [PROD_W-1:0]  prod_next;
  logic signed [COEF_W:0]    coeff_s;
  logic signed [DELTA_W-1:0] delta;
  logic signed [RES_W-1:0]   res;

  logic                      out_valid;
  temp_t                     out_temp;
  tag_t                      out_tag;
  logic                      out_sat;

  // Each stage moves when it is empty or the next one moves
  assign adv_out = !out_valid || result.ready;
  assign adv_mul = !mul_valid || adv_out;
  assign advance = !dif_valid || adv_mul;

  // Six neighbors minus six times the center
  assign nb_sum = DIFF_W'(taps.above) + DIFF_W'(taps.north) + DIFF_W'(taps.right) +
                  DIFF_W'(taps.left) + DIFF_W'(taps.south) + DIFF_W'(taps.below);
  assign center_x  = DIFF_W'(taps.center);
  assign diff_next = nb_sum - ((center_x <<< 2) + (center_x <<< 1));

  assign coeff_s   = signed'({1'b0, coeff});
  assign prod_next = dif_diff * coeff_s;

  // Arithmetic shift rounds toward minus infinity
  assign delta = mul_prod[PROD_W-1:FRAC_W];
  assign res   = RES_W'(mul_center) + RES_W'(delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      dif_valid <= 1'b0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        dif_valid <= win_valid;
      end
      if (adv_mul) begin
        mul_valid <= dif_valid;
      end
      if (adv_out) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dif_diff   <= diff_next;
      dif_center <= taps.center;
      dif_tag    <= tag;
    end
    if (adv_mul) begin
      mul_prod   <= prod_next;
      mul_center <= dif_center;
      mul_tag    <= dif_tag;
    end
    if (adv_out) begin
      out_tag <= mul_tag;
      if (res > RES_W'(TEMP_MAX)) begin
        out_temp <= TEMP_W'(TEMP_MAX);
        out_sat  <= 1'b1;
      end else if (res < RES_W'(TEMP_MIN)) begin
        out_temp <= TEMP_W'(TEMP_MIN);
        out_sat  <= 1'b1;
      end else begin
        out_temp <= res[TEMP_W-1:0];
        out_sat  <= 1'b0;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.next_temperature = out_temp;
  assign result.pos_x            = out_tag.pos_x;
  assign result.pos_y            = out_tag.pos_y;
  assign result.pos_z            = out_tag.pos_z;
  assign result.last             = out_tag.last;
  assign result.saturated        = out_sat;

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |->
      out_temp == TEMP_W'(TEMP_MAX) || out_temp == TEMP_W'(TEMP_MIN))
    else $error("saturated result not at a range limit");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !dif_valid && !mul_valid && !out_valid)
    else $error("pipeline holds words after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mul_valid && !adv_out |=> mul_valid && $stable(mul_prod))
    else $error("multiply stage dropped or overwritten while stalled");

endmodule

// ===== hw/rtl/heat_diffusion_stencil_3d_top.sv =====
// Top level of the 3D heat diffusion stencil: step coefficient register,
// voxel window and update pipeline. Depends on hds_pkg, hds_if, hds_window, hds_update.
`timescale 1ns / 1ps
//
// Usage
//   voxel  : padded volume, (EDGE_SIZE+2) x (COLUMN_HEIGHT+2) x (EDGE_SIZE+2) words,
//            x fastest, then y, then z, halo included. frame_start on a word moves
//            it to the origin; volumes may follow each other without it.
//   result : one word per interior voxel, emitted once the voxel above it arrives,
//            with its interior coordinates, a saturation flag and a last mark on
//            the final interior voxel of the volume.
//   cfg_we / cfg_data : step coefficient (unsigned Q0.16), write while idle.
// Throughput: one voxel per cycle while the result side does not stall; each delay
//   memory (about one plane deep, about one row deep) is read and written every word.
// Pipeline: after the accept of the voxel above it, a result passes the window register,
//   difference stage, multiply stage and output register before it is valid.
// Reset: position returns to the origin, coefficient clears to 0, the pipeline
//   empties. The delay memories are not cleared; the first two planes of each
//   volume fill them before any result reads them.
// Stall: a held result stalls only the stages behind it; intake stops once the
//   window register holds an interior voxel that the next stage cannot take.
//

module heat_diffusion_stencil_3d_top import hds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  coef_t        cfg_data,
  hds_voxel_if.sink    voxel,
  hds_result_if.source result
);

  coef_t step_coefficient;
  logic  win_valid;
  logic  advance;
  taps_t taps;
  tag_t  tag;

  // Coefficient register: hold between writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_coefficient <= '0;
    end else if (cfg_we) begin
      step_coefficient <= cfg_data;
    end
  end

  // Intake, delay memories and the seven-point window
  hds_window u_window (
    .clk      (clk),
    .rst      (rst),
    .voxel    (voxel),
    .advance  (advance),
    .win_valid(win_valid),
    .taps     (taps),
    .tag      (tag)
  );

  // Arithmetic and output register
  hds_update u_update (
    .clk      (clk),
    .rst      (rst),
    .win_valid(win_valid),
    .taps     (taps),
    .tag      (tag),
    .coeff    (step_coefficient),
    .advance  (advance),
    .result   (result)
  );

endmodule

// ===== verif/heat_diffusion_stencil_3d_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heat_diffusion_stencil_3d_top: streams padded voxel volumes,
// predicts every interior update and compares each result word in order.
// Depends on hds_pkg, hds_if and the RTL of heat_diffusion_stencil_3d_top.

module heat_diffusion_stencil_3d_top_tb;
  import hds_pkg::*;

  // Idle cycles before a coefficient write; covers the window, difference,
  // multiply and output registers with margin.
  localparam int DRAIN_CYCLES = 8;
  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  localparam int VOLUME_WORDS = PLANE_WORDS * PAD_Z;
  localparam int PROBE_ROWS   = 9;

  // One expected result word.
  typedef struct {
    temp_t              next_temperature;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_Z_W-1:0] pos_z;
    logic               saturated;
    logic               last;
  } voxel_update_t;

  // One directed probe: padded plane 0 filled with 'below', plane 1 with 'center',
  // then the word above interior voxel (0,0,0) carries 'above'. Only that word
  // produces a result, so its value follows from the row alone.
  typedef struct {
    bit    load_coef;
    coef_t coef;
    temp_t below;
    temp_t center;
    temp_t above;
    bit    typed;
    temp_t exp_temperature;
    bit    exp_saturated;
  } probe_row_t;

  // Content of random volumes.
  typedef enum int {FILL_NOISE, FILL_SMOOTH, FILL_HOT_SPOTS} fill_style_t;

  logic  clk      = 1'b0;
  logic  rst      = 1'b1;
  logic  cfg_we   = 1'b0;
  coef_t cfg_data = '0;

  hds_voxel_if  voxel_ch ();
  hds_result_if result_ch ();

  heat_diffusion_stencil_3d_top i_dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_data,
    .voxel  (voxel_ch),
    .result (result_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: two padded planes of history, the padded position of the
  // next voxel and the step coefficient as last written.
  // ---------------------------------------------------------------------------
  temp_t         plane_hist [2][PAD_Y][PAD_X];
  int unsigned   col_pos     = 0;
  int unsigned   row_pos     = 0;
  int unsigned   plane_pos   = 0;
  coef_t         diffusivity = '0;

  voxel_update_t pending_updates [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   sender_steady  = 0;
  int unsigned   sink_steady    = 0;
  int unsigned   sink_hold      = 0;

  probe_row_t    probe_table [PROBE_ROWS];

  // Clock: 10 ns period.
  initial begin
    forever #5 clk = ~clk;
  end

  // Place one voxel into the padded volume and return 1 with the updated
  // interior voxel when the word completes a stencil (it is the voxel above).
  function automatic bit diffuse_voxel(input temp_t above, input logic restart,
                                       output voxel_update_t upd);
    int unsigned x, y, z, cur, prv;
    longint      c, sum, diff, prod, res;
    bit          emits;
    emits = 1'b0;
    upd   = '{default: '0};
    // A frame start moves the position to the origin before the word is placed.
    if (restart) begin
      col_pos   = 0;
      row_pos   = 0;
      plane_pos = 0;
    end
    x   = col_pos;
    y   = row_pos;
    z   = plane_pos;
    cur = z & 1;
    prv = cur ^ 1;
    // Border words and the first two planes only fill the history.
    if (z >= 2 && x >= 1 && x <= PAD_X - 2 && y >= 1 && y <= PAD_Y - 2) begin
      c    = plane_hist[prv][y][x];
      sum  = longint'(plane_hist[prv][y][x-1]) + plane_hist[prv][y][x+1]
           + plane_hist[prv][y-1][x] + plane_hist[prv][y+1][x]
           + plane_hist[cur][y][x] + above;
      diff = sum - 6 * c;
      prod = diff * longint'(diffusivity);
      // Arithmetic shift rounds toward minus infinity.
      res  = c + (prod >>> FRAC_W);
      if (res > TEMP_MAX) begin
        res           = TEMP_MAX;
        upd.saturated = 1'b1;
      end else if (res < TEMP_MIN) begin
        res           = TEMP_MIN;
        upd.saturated = 1'b1;
      end
      upd.next_temperature = temp_t'(res);
      upd.pos_x            = POS_X_W'(x - 1);
      upd.pos_y            = POS_Y_W'(y - 1);
      upd.pos_z            = POS_Z_W'(z - 2);
      upd.last             = (x == PAD_X - 2 && y == PAD_Y - 2 && z == PAD_Z - 1);
      emits                = 1'b1;
    end
    // The entry two planes back was read above before this overwrite.
    plane_hist[cur][y][x] = above;
    // Advance x, then y, then z; wrap to the origin after the last padded voxel.
    col_pos = x + 1;
    if (col_pos >= PAD_X) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= PAD_Y) begin
        row_pos   = 0;
        plane_pos = (z + 1 >= PAD_Z) ? 0 : z + 1;
      end
    end
    return emits;
  endfunction

  // Idle length for either side: mostly none or short, now and then long,
  // and occasional stretches with no idling at all.
  function automatic int unsigned pick_gap(inout int unsigned steady);
    int unsigned roll;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    roll = $urandom_range(0, 999);
    if (roll < 3) begin
      steady = $urandom_range(50, 400);
      return 0;
    end
    if (roll < 600) return 0;
    if (roll < 900) return $urandom_range(1, 3);
    if (roll < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic temp_t fill_word(input fill_style_t style, input int base);
    int roll;
    roll = $urandom_range(0, 11);
    case (style)
      FILL_NOISE: begin
        return temp_t'($urandom);
      end
      FILL_HOT_SPOTS: begin
        if (roll == 0) return temp_t'(TEMP_MAX);
        if (roll == 1) return temp_t'(TEMP_MIN);
        return temp_t'(base + int'($urandom_range(0, 4095)) - 2048);
      end
      default: begin
        return temp_t'(base + int'($urandom_range(0, 511)) - 256);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Drive one voxel word and hold it until accepted; predict its result then.
  // Valid is left high after the accept so back-to-back words never drop it
  // and raise it again within one time step.
  task automatic send_word(input temp_t t, input logic fs, input bit typed = 1'b0,
                           input temp_t exp_t = '0, input bit exp_s = 1'b0);
    int unsigned   gap;
    voxel_update_t upd;
    gap = pick_gap(sender_steady);
    if (gap != 0) begin
      voxel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voxel_ch.valid       <= 1'b1;
    voxel_ch.temperature <= t;
    voxel_ch.frame_start <= fs;
    @(posedge clk);
    while (!voxel_ch.ready) @(posedge clk);
    if (diffuse_voxel(t, fs, upd)) begin
      // Directed rows with a value read off by hand override the prediction.
      if (typed) begin
        upd.next_temperature = exp_t;
        upd.saturated        = exp_s;
      end
      pending_updates.insert(pending_updates.size(), upd);
    end
  endtask

  // Drop valid and hold until every expected result word has come back.
  // Always advance at least one edge so valid is not raised in the same step.
  task automatic wait_for_drain();
    voxel_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_updates.size() != 0);
  endtask

  // Write the step coefficient once the pipeline is empty.
  task automatic load_coefficient(input coef_t value);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    diffusivity  = value;
  endtask

  // Stream 'words' voxels of a volume; optionally hold once mid-stream until drained.
  task automatic stream_volume(input fill_style_t style, input bit restart,
                               input int unsigned words, input bit hold_once);
    int unsigned i, hold_at;
    int          base;
    base    = int'($urandom_range(0, 16000)) - 8000;
    hold_at = $urandom_range(2 * PLANE_WORDS, words - 1);
    for (i = 0; i < words; i++) begin
      if (hold_once && i == hold_at) wait_for_drain();
      send_word(fill_word(style, base), restart && i == 0);
    end
  endtask

  // Random words with an occasional frame start anywhere in the volume.
  task automatic send_noise(input int unsigned words);
    int unsigned i;
    for (i = 0; i < words; i++)
      send_word(temp_t'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, most stalls short, a few long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      result_ch.ready <= 1'b0;
    end else begin
      sink_hold = pick_gap(sink_steady);
      result_ch.ready <= (sink_hold == 0);
    end
  end

  // Compare each accepted result word with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    voxel_update_t want;
    string         where;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("result word with nothing pending, next_temperature",
                        result_ch.next_temperature, 0);
      end else begin
        want  = pending_updates.pop_front();
        where = $sformatf(" at (%0d,%0d,%0d)", want.pos_x, want.pos_y, want.pos_z);
        if (result_ch.next_temperature !== want.next_temperature)
          report_mismatch({"next_temperature", where}, result_ch.next_temperature,
                          want.next_temperature);
        if (result_ch.pos_x !== want.pos_x)
          report_mismatch({"pos_x", where}, result_ch.pos_x, want.pos_x);
        if (result_ch.pos_y !== want.pos_y)
          report_mismatch({"pos_y", where}, result_ch.pos_y, want.pos_y);
        if (result_ch.pos_z !== want.pos_z)
          report_mismatch({"pos_z", where}, result_ch.pos_z, want.pos_z);
        if (result_ch.saturated !== want.saturated)
          report_mismatch({"saturated", where}, result_ch.saturated, want.saturated);
        if (result_ch.last !== want.last)
          report_mismatch({"last", where}, result_ch.last, want.last);
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (voxel_ch.valid && voxel_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("heat_diffusion_stencil_3d_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned r;
    voxel_ch.valid       <= 1'b0;
    voxel_ch.temperature <= '0;
    voxel_ch.frame_start <= 1'b0;

    // Directed probes. diff = below + above - 2*center, scaled by the coefficient.
    //                  load  coef      below              center             above
    //                  typed expected           sat
    // Coefficient still at its reset value: the center passes through.
    probe_table[0] = '{1'b0, 16'h0000, 16'sd100, 16'sd256, -16'sd7,
                       1'b1, 16'sd256, 1'b0};
    // Full coefficient, largest positive difference: clamp high.
    probe_table[1] = '{1'b1, 16'hFFFF, temp_t'(TEMP_MAX), temp_t'(TEMP_MIN), temp_t'(TEMP_MAX),
                       1'b1, temp_t'(TEMP_MAX), 1'b1};
    // Largest negative difference: clamp low.
    probe_table[2] = '{1'b0, 16'hFFFF, temp_t'(TEMP_MIN), temp_t'(TEMP_MAX), temp_t'(TEMP_MIN),
                       1'b1, temp_t'(TEMP_MIN), 1'b1};
    // Smallest coefficient, difference of -1: the shift rounds down to -1.
    probe_table[3] = '{1'b1, 16'h0001, -16'sd1, 16'sd0, 16'sd0,
                       1'b1, -16'sd1, 1'b0};
    // Difference of +1 truncates to 0.
    probe_table[4] = '{1'b0, 16'h0001, 16'sd1, 16'sd0, 16'sd0,
                       1'b1, 16'sd0, 1'b0};
    // Flat field at the top of the range: no change, no clamp.
    probe_table[5] = '{1'b1, 16'h4000, temp_t'(TEMP_MAX), temp_t'(TEMP_MAX), temp_t'(TEMP_MAX),
                       1'b1, temp_t'(TEMP_MAX), 1'b0};
    // Flat field at the bottom of the range.
    probe_table[6] = '{1'b0, 16'h4000, temp_t'(TEMP_MIN), temp_t'(TEMP_MIN), temp_t'(TEMP_MIN),
                       1'b1, temp_t'(TEMP_MIN), 1'b0};
    // Ordinary values, checked against the predictor.
    probe_table[7] = '{1'b1, 16'h8000, 16'sd300, -16'sd200, -16'sd500,
                       1'b0, 16'sd0, 1'b0};
    probe_table[8] = '{1'b1, 16'h2AAB, 16'sd1234, -16'sd4321, 16'sd17,
                       1'b0, 16'sd0, 1'b0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Each probe opens with a frame start, which also abandons the previous probe's
    // volume right after its first interior word in plane 2.
    for (r = 0; r < PROBE_ROWS; r++) begin
      if (probe_table[r].load_coef) load_coefficient(probe_table[r].coef);
      stream_volume(FILL_SMOOTH, 1'b1, 0, 1'b0);
      for (int unsigned i = 0; i < PLANE_WORDS; i++)
        send_word(probe_table[r].below, i == 0);
      for (int unsigned i = 0; i < PLANE_WORDS; i++)
        send_word(probe_table[r].center, 1'b0);
      // Halo row 0 of plane 2 and the halo word at x = 0 of row 1.
      for (int unsigned i = 0; i <= PAD_X; i++)
        send_word(temp_t'($urandom), 1'b0);
      send_word(probe_table[r].above, 1'b0, probe_table[r].typed,
                probe_table[r].exp_temperature, probe_table[r].exp_saturated);
    end

    // Random part. A volume cut short by a frame start, then noise.
    load_coefficient(coef_t'($urandom));
    stream_volume(FILL_NOISE, 1'b1, 2 * PLANE_WORDS + $urandom_range(1, 4 * PAD_X), 1'b1);
    send_noise(40);

    // Two whole volumes at full coefficient; the second follows with no frame
    // start, relying on the wrap to the origin.
    load_coefficient(16'hFFFF);
    stream_volume(FILL_HOT_SPOTS, 1'b1, VOLUME_WORDS, 1'b1);
    stream_volume(FILL_SMOOTH, 1'b0, VOLUME_WORDS, 1'b1);

    // Zero coefficient over noise: every result repeats its center.
    load_coefficient(16'h0000);
    stream_volume(FILL_NOISE, 1'b1, 2 * PLANE_WORDS + $urandom_range(1, 3 * PAD_X), 1'b0);
    send_noise(30);

    // One more broken volume with a random coefficient and hot spots.
    load_coefficient(coef_t'($urandom));
    stream_volume(FILL_HOT_SPOTS, 1'b1, 2 * PLANE_WORDS + PLANE_WORDS / 2, 1'b1);
    send_noise(30);

    // Let every result come back, then watch for strays.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("heat_diffusion_stencil_3d_top_tb: clean");
    end else begin
      $display("heat_diffusion_stencil_3d_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hds_pkg.sv
hw/rtl/hds_if.sv
hw/rtl/hds_ram.sv
hw/rtl/hds_window.sv
hw/rtl/hds_update.sv
hw/rtl/heat_diffusion_stencil_3d_top.sv
verif/heat_diffusion_stencil_3d_top_tb.sv
